>>> hdl/ptts_pkg.sv
// shared types, codes and constants of the periodic task tick scheduler
// no dependencies; imported by every other file of the block except ptts_ram
`default_nettype none

package ptts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int RESULT_CAP    = 16;
    localparam int NF_W          = $clog2(RESULT_CAP + 1);
    localparam int KEY_W         = 16;
    localparam int PER_W         = 16;
    localparam int SLOT_W        = 4;

    // function codes of an input item
    localparam logic [1:0] FUNC_REG  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_FIRE  = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;

    // reply status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_ARG   = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PER_W-1:0] per;
        logic [PER_W-1:0] cnt;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_REPLY,
        S_TICK,
        S_TEND
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic search_step;
        logic tick_step;
        logic reply;
        logic tick_end;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       in_valid;
        logic [1:0] func;
        logic       reject;
        logic       live_zero;
        logic       hit;
        logic       at_last;
        logic       out_free;
        logic       need_push;
    } t_stat;

endpackage

`default_nettype wire

>>> hdl/ptts_if.sv
// valid/ready channel interfaces of the scheduler: command in, result out
// depends on ptts_pkg for field widths
`default_nettype none

interface ptts_in_if import ptts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       func;
    logic [KEY_W-1:0] task_key;
    logic [PER_W-1:0] period;

    modport source (output valid, output func, output task_key, output period, input ready);
    modport sink   (input valid, input func, input task_key, input period, output ready);
endinterface

interface ptts_out_if import ptts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  fired_key;
    logic              last;

    modport source (output valid, output kind, output status, output slot,
                    output fired_key, output last, input ready);
    modport sink   (input valid, input kind, input status, input slot,
                    input fired_key, input last, output ready);
endinterface

`default_nettype wire

>>> hdl/ptts_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module ptts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/ptts_ctrl.sv
// sequencing state machine of the scheduler
// depends on ptts_pkg (state enum, command and status structs, function codes)
`default_nettype none

module ptts_ctrl import ptts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.func)
                    FUNC_REG: begin
                        n_state = (i_stat.reject || i_stat.live_zero) ? S_REPLY : S_SEARCH;
                    end
                    FUNC_DEL: begin
                        n_state = i_stat.live_zero ? S_REPLY : S_SEARCH;
                    end
                    FUNC_TICK: begin
                        n_state = i_stat.live_zero ? S_TEND : S_TICK;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_stat.hit || i_stat.at_last) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.reply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_TICK: begin
                // a firing that displaces a held firing waits for the output register
                if (!i_stat.need_push || i_stat.out_free) begin
                    o_cmd.tick_step = 1'b1;
                    if (i_stat.at_last) begin
                        n_state = S_TEND;
                    end
                end
            end
            S_TEND: begin
                if (i_stat.out_free) begin
                    o_cmd.tick_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/ptts_dp.sv
// datapath of the scheduler: task table ram, walk index, pack pointer,
// delete marks, held firing and output register
// depends on ptts_pkg, ptts_if and ptts_ram
`default_nettype none

module ptts_dp import ptts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    localparam int IDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cmd   i_cmd,
    output t_stat       o_stat,
    ptts_in_if.sink     i_in,
    ptts_out_if.source  o_out
);

    // latched command
    logic [1:0]        r_func;
    logic [KEY_W-1:0]  r_key;
    logic [PER_W-1:0]  r_period;

    // table walk
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_w;
    logic [CNT_W-1:0]  r_live;
    logic [MAX_TASKS-1:0] r_marks;
    logic              r_found;

    // firing held back until the next one shows whether it is the last
    logic              r_pend_v;
    logic [IDX_W-1:0]  r_pend_idx;
    logic [KEY_W-1:0]  r_pend_key;
    logic [NF_W-1:0]   r_nfire;

    // output register
    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [1:0]        r_status;
    logic [SLOT_W-1:0] r_slot;
    logic [KEY_W-1:0]  r_fkey;
    logic              r_last;

    logic              w_load;
    logic [CNT_W-1:0]  w_idx_ext;
    logic [CNT_W-1:0]  w_idx_nx;
    logic              w_at_last;
    logic              w_live_zero;
    logic              w_full;
    logic              w_reject;
    logic              w_hit;
    logic              w_out_free;
    logic [PER_W-1:0]  w_cinc;
    logic              w_fire;
    logic [PER_W-1:0]  w_cnew;
    logic              w_report;
    logic              w_mark;
    logic              w_need_push;
    logic              w_push;

    logic              w_re;
    logic [IDX_W-1:0]  w_raddr;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_entry            w_wdata;
    t_entry            w_q;

    logic [1:0]        w_rep_status;
    logic [SLOT_W-1:0] w_rep_slot;
    logic              w_append;

    logic [1:0]        n_kind;
    logic [1:0]        n_status;
    logic [SLOT_W-1:0] n_slot;
    logic [KEY_W-1:0]  n_fkey;
    logic              n_last;

    ptts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_load      = i_in.valid && i_cmd.in_ready;
    assign w_idx_ext   = CNT_W'(r_idx);
    assign w_idx_nx    = w_idx_ext + CNT_W'(1);
    assign w_at_last   = (w_idx_nx == r_live);
    assign w_live_zero = (r_live == '0);
    assign w_full      = (r_live == CNT_W'(MAX_TASKS));
    assign w_reject    = (r_key == '0) || (r_period == '0);
    assign w_hit       = (w_q.key == r_key);
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_cinc      = w_q.cnt + PER_W'(1);
    assign w_fire      = (w_cinc >= w_q.per);
    assign w_cnew      = w_fire ? '0 : w_cinc;
    assign w_report    = (r_nfire < NF_W'(RESULT_CAP));
    assign w_mark      = r_marks[r_idx];
    assign w_need_push = w_fire && w_report && r_pend_v;
    assign w_append    = !r_found && !w_full;

    assign o_stat.in_valid  = i_in.valid;
    assign o_stat.func      = r_func;
    assign o_stat.reject    = w_reject;
    assign o_stat.live_zero = w_live_zero;
    assign o_stat.hit       = w_hit;
    assign o_stat.at_last   = w_at_last;
    assign o_stat.out_free  = w_out_free;
    assign o_stat.need_push = w_need_push;

    assign i_in.ready = i_cmd.in_ready;

    // reply to register or destroy
    always_comb begin
        w_rep_status = STS_OK;
        w_rep_slot   = '0;
        if (r_func == FUNC_REG) begin
            if (w_reject) begin
                w_rep_status = STS_BAD_ARG;
            end else if (r_found) begin
                w_rep_slot = SLOT_W'(w_idx_ext);
            end else if (!w_full) begin
                w_rep_slot = SLOT_W'(r_live);
            end else begin
                w_rep_status = STS_FULL;
            end
        end else begin
            if (r_found) begin
                w_rep_slot = SLOT_W'(w_idx_ext);
            end else begin
                w_rep_status = STS_NOT_FOUND;
            end
        end
    end

    // table ram ports: walk reads one entry ahead, pack writes at or behind the walk
    always_comb begin
        w_re    = 1'b0;
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = w_q;
        if (w_load) begin
            w_re = 1'b1;
        end
        if (i_cmd.search_step && !w_hit && !w_at_last) begin
            w_re    = 1'b1;
            w_raddr = w_idx_nx[IDX_W-1:0];
        end
        if (i_cmd.tick_step) begin
            if (!w_at_last) begin
                w_re    = 1'b1;
                w_raddr = w_idx_nx[IDX_W-1:0];
            end
            if (!w_mark) begin
                w_we        = 1'b1;
                w_waddr     = r_w[IDX_W-1:0];
                w_wdata.cnt = w_cnew;
            end
        end
        if (i_cmd.reply && (r_func == FUNC_REG) && !w_reject && (r_found || w_append)) begin
            w_we        = 1'b1;
            w_waddr     = r_found ? r_idx : r_live[IDX_W-1:0];
            w_wdata.key = r_key;
            w_wdata.per = r_period;
            w_wdata.cnt = '0;
        end
    end

    // next output item
    always_comb begin
        w_push   = 1'b0;
        n_kind   = KIND_REPLY;
        n_status = STS_OK;
        n_slot   = '0;
        n_fkey   = '0;
        n_last   = 1'b1;
        if (i_cmd.reply) begin
            w_push   = 1'b1;
            n_status = w_rep_status;
            n_slot   = w_rep_slot;
        end else if (i_cmd.tick_step && w_need_push) begin
            w_push = 1'b1;
            n_kind = KIND_FIRE;
            n_slot = SLOT_W'(r_pend_idx);
            n_fkey = r_pend_key;
            n_last = 1'b0;
        end else if (i_cmd.tick_end) begin
            w_push = 1'b1;
            if (r_pend_v) begin
                n_kind = KIND_FIRE;
                n_slot = SLOT_W'(r_pend_idx);
                n_fkey = r_pend_key;
            end else begin
                n_kind = KIND_IDLE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_w         <= '0;
            r_live      <= '0;
            r_marks     <= '0;
            r_found     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_nfire     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_idx   <= '0;
                r_w     <= '0;
                r_found <= 1'b0;
                r_nfire <= '0;
            end
            if (i_cmd.search_step) begin
                if (w_hit) begin
                    r_found <= 1'b1;
                end else if (!w_at_last) begin
                    r_idx <= w_idx_nx[IDX_W-1:0];
                end
            end
            if (i_cmd.tick_step) begin
                if (!w_at_last) begin
                    r_idx <= w_idx_nx[IDX_W-1:0];
                end
                if (!w_mark) begin
                    r_w <= r_w + CNT_W'(1);
                end
                if (w_fire && w_report) begin
                    r_pend_v <= 1'b1;
                    r_nfire  <= r_nfire + NF_W'(1);
                end
            end
            if (i_cmd.tick_end) begin
                r_live   <= r_w;
                r_marks  <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.reply) begin
                if ((r_func == FUNC_REG) && !w_reject && w_append) begin
                    r_live <= r_live + CNT_W'(1);
                end
                if ((r_func == FUNC_DEL) && r_found) begin
                    r_marks[r_idx] <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_func   <= i_in.func;
            r_key    <= i_in.task_key;
            r_period <= i_in.period;
        end
        if (i_cmd.tick_step && w_fire && w_report) begin
            r_pend_idx <= r_idx;
            r_pend_key <= w_q.key;
        end
        if (w_push) begin
            r_kind   <= n_kind;
            r_status <= n_status;
            r_slot   <= n_slot;
            r_fkey   <= n_fkey;
            r_last   <= n_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_kind;
    assign o_out.status    = r_status;
    assign o_out.slot      = r_slot;
    assign o_out.fired_key = r_fkey;
    assign o_out.last      = r_last;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(MAX_TASKS))
        else $error("live count above table depth");

    a_pack_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_step |-> (r_w <= w_idx_ext))
        else $error("pack pointer ahead of walk index");

    a_marks_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_marks >> r_live) == '0)
        else $error("delete mark on an entry beyond the live count");

    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_end |=> !r_pend_v && (r_nfire <= NF_W'(RESULT_CAP)))
        else $error("held firing survived the end of a tick");

endmodule

`default_nettype wire

>>> hdl/periodic_task_tick_scheduler_top.sv
// top level of the periodic task tick scheduler: controller plus datapath
// depends on ptts_pkg, ptts_if, ptts_ram, ptts_ctrl and ptts_dp
//
// usage
//   i_cmd carries one command per transfer: register/update a task (key and
//   period), destroy a task (key), or one timer tick. o_res carries results:
//   one reply per register or destroy, and per tick one result per task that
//   fired (first sixteen reported) or a single "nothing fired" result; the
//   final result of each command has last set. an unused function code is
//   dropped with no result.
//   the task table sits in a ram with registered read; a key search or tick
//   walks it one entry per cycle, unless a tick stalls on o_res, with the next
//   read issued while the current entry is handled. a register or destroy
//   goes through the accept state, a decode state, a key search over the live
//   entries (skipped for a rejected or empty case) and a reply state. a tick
//   advances counters, reports firings and packs out deleted entries in the
//   same walk. one command is worked on at a time; i_cmd.ready is high only while idle.
//   a finished result sits in the output register, so the next command is
//   taken while it waits. when o_res stalls, a reply or the tick's closing
//   result waits in place, and a tick walk pauses on a firing that would
//   need a second result slot.
//   synchronous active-low reset empties the table and clears all delete
//   marks and the output register; entries are written before they are read,
//   so the ram needs no clearing pass.
`default_nettype none

module periodic_task_tick_scheduler_top import ptts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptts_in_if.sink    i_cmd,
    ptts_out_if.source o_res
);

    // command and status between the state machine and the datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: idle, decode, search, reply, tick walk, tick end
    ptts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // table, walk counters, marks and output register
    ptts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in    (i_cmd),
        .o_out   (o_res)
    );

endmodule

`default_nettype wire

>>> tb/ptts_result_checker.sv
`timescale 1ns / 1ps
// scoreboard for the periodic task tick scheduler: keeps its own copy of the task table,
// works out the results of every command transfer and compares the result channel with them
// depends on ptts_pkg and the ptts_in_if / ptts_out_if channel interfaces
`default_nettype none

module ptts_result_checker import ptts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ptts_in_if        i_cmd_mon,
    ptts_out_if       i_res_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  fired_key;
        logic              last;
    } t_sched_res;

    t_entry                task_tab [MAX_TASKS];
    int                    live_n;
    logic [MAX_TASKS-1:0]  del_marks;
    t_sched_res            due_q [$];
    int                    fails = 0;

    function automatic int find_task(input logic [KEY_W-1:0] key);
        for (int i = 0; i < live_n; i++) begin
            if (task_tab[i].key == key) return i;
        end
        return -1;
    endfunction

    function automatic t_sched_res make_res(input logic [1:0] kind, input logic [1:0] status,
                                            input int slot, input logic [KEY_W-1:0] key,
                                            input logic last);
        t_sched_res r;
        r.kind      = kind;
        r.status    = status;
        r.slot      = slot[SLOT_W-1:0];
        r.fired_key = key;
        r.last      = last;
        return r;
    endfunction

    // one command transfer: update the table copy and queue the results it causes
    task automatic apply_command(input logic [1:0] func, input logic [KEY_W-1:0] key,
                                 input logic [PER_W-1:0] per);
        int               hit;
        int               n_fired;
        int               w;
        logic [PER_W-1:0] c;
        t_sched_res       held;
        bit               have_held;
        have_held = 1'b0;
        n_fired   = 0;
        case (func)
            FUNC_REG: begin
                if (key == '0 || per == '0) begin
                    due_q.push_back(make_res(KIND_REPLY, STS_BAD_ARG, 0, '0, 1'b1));
                end else begin
                    hit = find_task(key);
                    if (hit >= 0) begin
                        // update keeps any pending delete mark
                        task_tab[hit].per = per;
                        task_tab[hit].cnt = '0;
                        due_q.push_back(make_res(KIND_REPLY, STS_OK, hit, '0, 1'b1));
                    end else if (live_n < MAX_TASKS) begin
                        task_tab[live_n].key = key;
                        task_tab[live_n].per = per;
                        task_tab[live_n].cnt = '0;
                        due_q.push_back(make_res(KIND_REPLY, STS_OK, live_n, '0, 1'b1));
                        live_n++;
                    end else begin
                        due_q.push_back(make_res(KIND_REPLY, STS_FULL, 0, '0, 1'b1));
                    end
                end
            end
            FUNC_DEL: begin
                hit = find_task(key);
                if (hit >= 0) begin
                    del_marks[hit] = 1'b1;
                    due_q.push_back(make_res(KIND_REPLY, STS_OK, hit, '0, 1'b1));
                end else begin
                    due_q.push_back(make_res(KIND_REPLY, STS_NOT_FOUND, 0, '0, 1'b1));
                end
            end
            FUNC_TICK: begin
                // firing pass; the newest firing is held back so it can get the last flag
                for (int i = 0; i < live_n; i++) begin
                    c = task_tab[i].cnt + 1'b1;
                    if (c >= task_tab[i].per) begin
                        c = '0;
                        if (n_fired < RESULT_CAP) begin
                            if (have_held) due_q.push_back(held);
                            held      = make_res(KIND_FIRE, STS_OK, i, task_tab[i].key, 1'b0);
                            have_held = 1'b1;
                            n_fired++;
                        end
                    end
                    task_tab[i].cnt = c;
                end
                if (have_held) begin
                    held.last = 1'b1;
                    due_q.push_back(held);
                end else begin
                    due_q.push_back(make_res(KIND_IDLE, STS_OK, 0, '0, 1'b1));
                end
                // pack out marked entries in order
                w = 0;
                for (int i = 0; i < live_n; i++) begin
                    if (!del_marks[i]) begin
                        task_tab[w] = task_tab[i];
                        w++;
                    end
                end
                live_n    = w;
                del_marks = '0;
            end
            default: begin
                // unused function code: dropped without a result
            end
        endcase
    endtask

    function automatic bit field_bad(input string name, input logic [KEY_W-1:0] exp_v,
                                     input logic [KEY_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_result(input t_sched_res got);
        t_sched_res exp_r;
        int         bad;
        if (due_q.size() == 0) begin
            $error("result with nothing expected: kind %0d status %0d slot %0d key %0d last %0d",
                   got.kind, got.status, got.slot, got.fired_key, got.last);
            fails++;
        end else begin
            exp_r = due_q.pop_front();
            bad   = field_bad("kind", exp_r.kind, got.kind)
                  + field_bad("status", exp_r.status, got.status)
                  + field_bad("slot", exp_r.slot, got.slot)
                  + field_bad("fired_key", exp_r.fired_key, got.fired_key)
                  + field_bad("last", exp_r.last, got.last);
            if (bad != 0) fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            live_n    = 0;
            del_marks = '0;
            due_q.delete();
        end else begin
            // retire the result first: it always belongs to an older command
            if (i_res_mon.valid && i_res_mon.ready) begin
                check_result(make_res(i_res_mon.kind, i_res_mon.status, int'(i_res_mon.slot),
                                      i_res_mon.fired_key, i_res_mon.last));
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready) begin
                apply_command(i_cmd_mon.func, i_cmd_mon.task_key, i_cmd_mon.period);
            end
        end
        o_pending    <= due_q.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

>>> tb/periodic_task_tick_scheduler_top_test.sv
`timescale 1ns / 1ps
// top of the scheduler testbench: clock, reset, command stimulus, result back-pressure
// and the verdict; depends on ptts_pkg, ptts_if, the scheduler rtl and ptts_result_checker
`default_nettype none

module periodic_task_tick_scheduler_top_test import ptts_pkg::*; ();

    // the one code the block leaves unused; it must be dropped silently
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int ITEM_TARGET = 280;   // counted random items, dropped codes excluded
    localparam int QUIET_TAIL  = 40;    // closing items run with no idling at all
    localparam int DRAIN_EVERY = 70;    // sender waits for an empty scoreboard this often
    localparam int KEY_POOL_N  = 24;    // small pool so updates and destroys hit live entries
    localparam int TAIL_CYCLES = 60;    // settling run after the scoreboard has drained

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   quiet_tail = 1'b0;

    ptts_in_if  cmd_ch ();
    ptts_out_if res_ch ();

    periodic_task_tick_scheduler_top #(
        .MAX_TASKS (MAX_TASKS_DEF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    ptts_result_checker #(
        .MAX_TASKS (MAX_TASKS_DEF)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // one command transfer, with an occasional idle burst in front of it;
    // returns in the time step of the transfer with valid still high
    task automatic send_cmd(input logic [1:0] func, input logic [KEY_W-1:0] key,
                            input logic [PER_W-1:0] per);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.func     <= func;
        cmd_ch.task_key <= key;
        cmd_ch.period   <= per;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
    endtask

    // hold the sender off until every predicted result has come back
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // result side: random stall bursts, then ready runs; none once the tail starts
    initial begin
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        logic [KEY_W-1:0] key_pool [KEY_POOL_N];
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [PER_W-1:0] per;
        int               counted;
        int               pick;
        int               w;

        cmd_ch.valid    <= 1'b0;
        cmd_ch.func     <= FUNC_REG;
        cmd_ch.task_key <= '0;
        cmd_ch.period   <= '0;
        i_rst_n         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part ---
        send_cmd(FUNC_REG, 16'd0, 16'd5);           // null key rejected
        send_cmd(FUNC_REG, 16'd7, 16'd0);           // zero period rejected
        send_cmd(FUNC_DEL, 16'd0, 16'd0);           // destroy on empty table, key 0 never matches
        send_cmd(FUNC_TICK, 16'd0, 16'd0);          // tick on empty table fires nothing
        send_cmd(FUNC_NONE, 16'hFFFF, 16'hFFFF);    // unused code, no result
        send_cmd(FUNC_REG, 16'hFFFF, 16'hFFFF);     // widest key and period, slot 0
        send_cmd(FUNC_REG, 16'd1, 16'd2);           // appended at slot 1
        send_cmd(FUNC_REG, 16'd1, 16'd1);           // update in place
        send_cmd(FUNC_DEL, 16'hFFFF, 16'd0);        // mark slot 0
        send_cmd(FUNC_REG, 16'hFFFF, 16'd1);        // update of a marked entry keeps the mark
        for (int i = 0; i < 14; i++) begin
            send_cmd(FUNC_REG, 16'h0100 + 16'(i), 16'd1);
        end
        send_cmd(FUNC_REG, 16'h0200, 16'd1);        // table full
        send_cmd(FUNC_TICK, 16'd0, 16'd0);          // all sixteen fire, marked one included
        wait_drained();

        // --- random part ---
        foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(1, 65535));
        key_pool[0] = 16'hFFFF;
        key_pool[1] = 16'h0001;
        counted = 0;
        while (counted < ITEM_TARGET) begin
            quiet_tail = (counted >= ITEM_TARGET - QUIET_TAIL);
            if ($urandom_range(0, 6) == 0) key = 16'($urandom_range(1, 65535));
            else                           key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
            pick = $urandom_range(0, 19);
            if (pick < 16)      per = 16'($urandom_range(1, 6));
            else if (pick < 19) per = 16'($urandom_range(7, 40));
            else                per = 16'($urandom_range(1, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                func = FUNC_TICK;
            end else if (pick < 70) begin
                func = FUNC_REG;
            end else if (pick < 90) begin
                func = FUNC_DEL;
            end else if (pick < 94) begin
                func = FUNC_NONE;
            end else begin
                // malformed: null key or zero period
                func = ($urandom_range(0, 2) == 0) ? FUNC_DEL : FUNC_REG;
                if (func == FUNC_DEL || $urandom_range(0, 1) == 0) key = '0;
                else                                               per = '0;
            end
            send_cmd(func, key, per);
            if (func != FUNC_NONE) begin
                counted++;
                if (counted % DRAIN_EVERY == 0 && counted < ITEM_TARGET - QUIET_TAIL) begin
                    wait_drained();
                end
            end
        end
        cmd_ch.valid <= 1'b0;

        // --- drain and verdict ---
        @(posedge i_clk);
        for (w = 0; w < 20000 && pending != 0; w++) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
